// File: hdl/b36md5_pkg.sv
`timescale 1ns / 1ps
package b36md5_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5_state_t;

    localparam md5_state_t MD5_IV = '{
        a: 32'h67452301, b: 32'hefcdab89, c: 32'h98badcfe, d: 32'h10325476
    };

    localparam int IDX_W = 26;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 1'b1;

    // reciprocal of 36 scaled by 2^32, rounded up
    localparam logic [26:0] RECIP_36 = 27'd119304648;

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // base-36 digit to charset byte: a-z then 0-9
    function automatic logic [7:0] digit_char(input logic [5:0] dg);
        logic [7:0] r;
        if (dg < 6'd26)
            r = 8'h61 + {2'b00, dg};
        else
            r = 8'h30 + {2'b00, dg} - 8'd26;
        return r;
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic md5_state_t md5_round(input md5_state_t st, input logic [1:0] grp,
                                             input logic [31:0] k, input logic [31:0] wg,
                                             input logic [4:0] s);
        logic [31:0] f;
        logic [31:0] t;
        logic [31:0] rot;
        md5_state_t nx;
        case (grp)
            2'd0:    f = (st.b & st.c) | (~st.b & st.d);
            2'd1:    f = (st.d & st.b) | (~st.d & st.c);
            2'd2:    f = st.b ^ st.c ^ st.d;
            default: f = st.c ^ (st.b | ~st.d);
        endcase
        t = st.a + f + k + wg;
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
        nx.a = st.d;
        nx.d = st.c;
        nx.c = st.b;
        nx.b = st.b + rot;
        return nx;
    endfunction

endpackage

// File: hdl/b36md5_if.sv
`timescale 1ns / 1ps
interface b36md5_cand_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cand_length;
    logic [25:0] cand_index;

    modport source (output valid, cand_length, cand_index, input ready);
    modport sink (input valid, cand_length, cand_index, output ready);
endinterface

interface b36md5_res_if #(parameter int MAX_LEN = 5);
    logic                   valid;
    logic                   ready;
    logic                   match;
    logic [2:0]             out_length;
    logic [8*MAX_LEN-1:0]   candidate;
    logic [63:0]            digest_high;
    logic [63:0]            digest_low;

    modport source (output valid, match, out_length, candidate, digest_high, digest_low,
                    input ready);
    modport sink (input valid, match, out_length, candidate, digest_high, digest_low,
                  output ready);
endinterface

interface b36md5_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/base36_md5_candidate_matcher.sv
`timescale 1ns / 1ps
// Fully pipelined base-36 MD5 matcher: one candidate word is accepted every clock unless
// the output is stalled, and its result word passes through MAX_LEN + 67 register stages:
// one input stage, one base-36 digit stage per character, one stage per MD5 round (64),
// a digest add stage and an output/compare stage. The whole pipe advances together, so a
// stalled output holds every stage and input ready drops only while the output word is
// waiting. The target registers are written through the cfg port, which is always ready;
// write them while no candidate is in flight.
module base36_md5_candidate_matcher #(
    parameter int MAX_LEN = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    b36md5_cand_if.sink          cand,
    b36md5_res_if.source         res,
    b36md5_cfg_if.sink           cfg
);
    import b36md5_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int DW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int NW    = (MAX_LEN + 4) / 4;
    localparam int CW    = 8 * MAX_LEN;

    logic adv;

    logic [63:0] target_high_reg;
    logic [63:0] target_low_reg;

    // front and digit stages
    logic                         vd_reg  [MAX_LEN+1];
    logic [LEN_W-1:0]             ld_reg  [MAX_LEN+1];
    logic [IDX_W-1:0]             x_reg   [MAX_LEN+1];
    logic [MAX_LEN-1:0][5:0]      dg_reg  [MAX_LEN+1];

    // round stages
    logic                         rv_reg  [64];
    logic [LEN_W-1:0]             rl_reg  [64];
    logic [CW-1:0]                rc_reg  [64];
    logic [NW-1:0][31:0]          rw_reg  [64];
    md5_state_t                   st_reg  [64];

    // digest add stage
    logic                         fv_reg;
    logic [LEN_W-1:0]             fl_reg;
    logic [CW-1:0]                fc_reg;
    logic [63:0]                  fh_reg;
    logic [63:0]                  flo_reg;

    // output stage
    logic                         ov_reg;
    logic                         om_reg;
    logic [2:0]                   ol_reg;
    logic [CW-1:0]                oc_reg;
    logic [63:0]                  oh_reg;
    logic [63:0]                  olo_reg;

    logic [LEN_W-1:0]             len_clamp;
    logic [7:0]                   cb      [MAX_LEN];
    logic [CW-1:0]                cword;
    logic [NW-1:0][31:0]          wmsg;

    assign adv       = !ov_reg || res.ready;
    assign cand.ready = adv;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_high_reg <= '0;
            target_low_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TARGET_HIGH: target_high_reg <= cfg.data;
                REG_TARGET_LOW:  target_low_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (cand.cand_length == 3'd0)
            len_clamp = LEN_W'(1);
        else if (int'(cand.cand_length) > MAX_LEN)
            len_clamp = LEN_W'(MAX_LEN);
        else
            len_clamp = LEN_W'(cand.cand_length);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg[0] <= 1'b0;
        else if (adv)
            vd_reg[0] <= cand.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ld_reg[0] <= len_clamp;
            x_reg[0]  <= cand.cand_index;
            dg_reg[0] <= '0;
        end
    end

    // one base-36 digit per stage, least significant first
    for (genvar j = 0; j < MAX_LEN; j++)
    begin : g_digit
        logic [52:0]             prod;
        logic [20:0]             q;
        logic [IDX_W-1:0]        q36;
        logic [IDX_W-1:0]        rem;
        logic [MAX_LEN-1:0][5:0] dg_next;

        assign prod = x_reg[j] * RECIP_36;
        assign q    = prod[52:32];
        assign q36  = IDX_W'({q, 5'b0}) + IDX_W'({q, 2'b0});
        assign rem  = x_reg[j] - q36;

        always_comb
        begin
            dg_next    = dg_reg[j];
            dg_next[j] = rem[5:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vd_reg[j+1] <= 1'b0;
            else if (adv)
                vd_reg[j+1] <= vd_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ld_reg[j+1] <= ld_reg[j];
                x_reg[j+1]  <= IDX_W'(q);
                dg_reg[j+1] <= dg_next;
            end
        end
    end

    // candidate bytes and padded message words
    always_comb
    begin
        logic [LEN_W-1:0] pos;
        logic [7:0]       bt;
        cword = '0;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            pos   = ld_reg[MAX_LEN] - LEN_W'(1) - LEN_W'(i);
            cb[i] = digit_char(dg_reg[MAX_LEN][pos[DW-1:0]]);
            if (i < int'(ld_reg[MAX_LEN]))
                cword[CW-1-8*i -: 8] = cb[i];
        end
        wmsg = '0;
        for (int b = 0; b < 4 * NW; b++)
        begin
            if (b < MAX_LEN && b < int'(ld_reg[MAX_LEN]))
                bt = cb[b % MAX_LEN];
            else if (b == int'(ld_reg[MAX_LEN]))
                bt = 8'h80;
            else
                bt = 8'h00;
            wmsg[b / 4][8 * (b % 4) +: 8] = bt;
        end
    end

    for (genvar r = 0; r < 64; r++)
    begin : g_round
        localparam int GRP = r / 16;
        localparam int G   = (GRP == 0) ? r :
                             (GRP == 1) ? ((5 * r + 1) % 16) :
                             (GRP == 2) ? ((3 * r + 5) % 16) : ((7 * r) % 16);

        md5_state_t          st_in;
        logic [NW-1:0][31:0] w_in;
        logic [LEN_W-1:0]    l_in;
        logic [CW-1:0]       c_in;
        logic                v_in;
        logic [31:0]         wg;

        if (r == 0)
        begin : g_first
            assign st_in = MD5_IV;
            assign w_in  = wmsg;
            assign l_in  = ld_reg[MAX_LEN];
            assign c_in  = cword;
            assign v_in  = vd_reg[MAX_LEN];
        end
        else
        begin : g_next
            assign st_in = st_reg[r-1];
            assign w_in  = rw_reg[r-1];
            assign l_in  = rl_reg[r-1];
            assign c_in  = rc_reg[r-1];
            assign v_in  = rv_reg[r-1];
        end

        always_comb
        begin
            if (G < NW)
                wg = w_in[G % NW];
            else if (G == 14)
                wg = 32'(l_in) << 3;
            else
                wg = '0;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rv_reg[r] <= 1'b0;
            else if (adv)
                rv_reg[r] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[r] <= md5_round(st_in, 2'(GRP), MD5_K[r], wg, MD5_S[4 * GRP + r % 4]);
                rw_reg[r] <= w_in;
                rl_reg[r] <= l_in;
                rc_reg[r] <= c_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            fv_reg <= rv_reg[63];
            ov_reg <= fv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fl_reg  <= rl_reg[63];
            fc_reg  <= rc_reg[63];
            fh_reg  <= {bswap32(MD5_IV.a + st_reg[63].a), bswap32(MD5_IV.b + st_reg[63].b)};
            flo_reg <= {bswap32(MD5_IV.c + st_reg[63].c), bswap32(MD5_IV.d + st_reg[63].d)};
            om_reg  <= (fh_reg == target_high_reg) && (flo_reg == target_low_reg);
            ol_reg  <= 3'(fl_reg);
            oc_reg  <= fc_reg;
            oh_reg  <= fh_reg;
            olo_reg <= flo_reg;
        end
    end

    assign res.valid       = ov_reg;
    assign res.match       = om_reg;
    assign res.out_length  = ol_reg;
    assign res.candidate   = oc_reg;
    assign res.digest_high = oh_reg;
    assign res.digest_low  = olo_reg;

endmodule

// File: hdl/b36md5_checker.sv
`timescale 1ns / 1ps
module b36md5_checker #(
    parameter int MAX_LEN = 5
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cand_ready,
    input logic                 res_valid,
    input logic                 res_ready,
    input logic [2:0]           out_length,
    input logic [8*MAX_LEN-1:0] candidate
);
    logic [7:0] first_char;

    assign first_char = candidate[8*MAX_LEN-1 -: 8];

    // a waiting result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(candidate))
        else $error("result word dropped while stalled");

    // the pipe must not take a word while its output is blocked
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !cand_ready)
        else $error("input accepted while output stalled");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_length != 3'd0 && int'(out_length) <= MAX_LEN)
        else $error("reported length out of range");

    a_first_char: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (first_char >= 8'h61 && first_char <= 8'h7a) ||
                      (first_char >= 8'h30 && first_char <= 8'h39))
        else $error("first candidate byte outside charset");

endmodule

bind base36_md5_candidate_matcher b36md5_checker #(.MAX_LEN(MAX_LEN)) u_b36md5_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_ready (cand.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .out_length (res.out_length),
    .candidate  (res.candidate)
);

// File: sim/tb_base36_md5_candidate_matcher.sv
`timescale 1ns / 1ps
module tb_base36_md5_candidate_matcher;
    import b36md5_pkg::*;

    localparam int CAND_LEN = 5;
    localparam int PIPE_DEPTH = CAND_LEN + 68;

    typedef struct packed {
        logic        match;
        logic [2:0]  out_length;
        logic [39:0] candidate;
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } match_word_t;

    logic clk;
    logic rst_n;

    b36md5_cand_if cand ();
    b36md5_res_if #(.MAX_LEN(CAND_LEN)) res ();
    b36md5_cfg_if cfg ();

    base36_md5_candidate_matcher #(.MAX_LEN(CAND_LEN)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cand  (cand),
        .res   (res),
        .cfg   (cfg)
    );

    match_word_t pending_words[$];
    logic [63:0] target_hi;
    logic [63:0] target_lo;
    int          fail_count;
    int          hold_cycles;
    bit          allow_stall;

    // 32-bit left rotate
    function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic match_word_t predict_match(input logic [2:0] len_in,
                                                  input logic [25:0] idx_in);
        logic [7:0]  chars [8];
        logic [7:0]  blk [64];
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        logic [31:0] h [4];
        logic [25:0] idx;
        logic [5:0]  dg;
        logic [7:0]  dig [16];
        int          len, g, s;
        match_word_t r;
        len = int'(len_in);
        if (len < 1) len = 1;
        if (len > CAND_LEN) len = CAND_LEN;
        idx = idx_in;
        for (int i = len - 1; i >= 0; i--)
        begin
            dg = 6'(idx % 36);
            chars[i] = (dg < 26) ? 8'h61 + dg : 8'h30 + dg - 26;
            idx = idx / 36;
        end
        r.candidate = '0;
        for (int i = 0; i < len; i++)
            r.candidate[39 - 8*i -: 8] = chars[i];
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        for (int i = 0; i < len; i++)
            blk[i] = chars[i];
        blk[len] = 8'h80;
        blk[56] = 8'(len * 8);
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
        for (int i = 0; i < 64; i++)
        begin
            if (i < 16)
            begin
                f = (b & c) | (~b & d); g = i;
            end
            else if (i < 32)
            begin
                f = (d & b) | (~d & c); g = (5*i + 1) % 16;
            end
            else if (i < 48)
            begin
                f = b ^ c ^ d; g = (3*i + 5) % 16;
            end
            else
            begin
                f = c ^ (b | ~d); g = (7*i) % 16;
            end
            case (i / 16)
                0: s = (i%4 == 0) ? 7 : (i%4 == 1) ? 12 : (i%4 == 2) ? 17 : 22;
                1: s = (i%4 == 0) ? 5 : (i%4 == 1) ? 9 : (i%4 == 2) ? 14 : 20;
                2: s = (i%4 == 0) ? 4 : (i%4 == 1) ? 11 : (i%4 == 2) ? 16 : 23;
                default: s = (i%4 == 0) ? 6 : (i%4 == 1) ? 10 : (i%4 == 2) ? 15 : 21;
            endcase
            t = d; d = c; c = b;
            b = b + rotl(a + f + MD5_K[i] + w[g], s);
            a = t;
        end
        h[0] = 32'h67452301 + a; h[1] = 32'hefcdab89 + b;
        h[2] = 32'h98badcfe + c; h[3] = 32'h10325476 + d;
        for (int i = 0; i < 16; i++)
            dig[i] = h[i/4][8*(i%4) +: 8];
        for (int i = 0; i < 8; i++)
        begin
            r.digest_high[63 - 8*i -: 8] = dig[i];
            r.digest_low[63 - 8*i -: 8] = dig[8 + i];
        end
        r.out_length = 3'(len);
        r.match = (r.digest_high == target_hi) && (r.digest_low == target_lo);
        return r;
    endfunction

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic send_candidate(input logic [2:0] len, input logic [25:0] idx);
        cand.valid       <= 1'b1;
        cand.cand_length <= len;
        cand.cand_index  <= idx;
        @(posedge clk);
        while (!cand.ready)
            @(posedge clk);
        pending_words.push_back(predict_match(len, idx));
        // burst/gap shaping: lower valid only when a gap follows
        if ($urandom_range(0, 3) == 0)
        begin
            cand.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic pause_sender();
        cand.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_pipe();
        pause_sender();
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
    endtask

    task automatic write_target(input logic [63:0] hi, input logic [63:0] lo);
        cfg.valid <= 1'b1;
        cfg.index <= REG_TARGET_HIGH;
        cfg.data  <= hi;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        target_hi = hi;
        cfg.index <= REG_TARGET_LOW;
        cfg.data  <= lo;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        target_lo = lo;
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // result checker with its own stall pattern
    always @(posedge clk)
    begin
        match_word_t exp_w;
        if (rst_n)
        begin
            if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
            if (res.valid && res.ready)
            begin
                if (pending_words.size() == 0)
                begin
                    $error("unexpected word: candidate %h", res.candidate);
                    fail_count++;
                end
                else
                begin
                    exp_w = pending_words.pop_front();
                    if (res.match !== exp_w.match)
                    begin
                        $error("match exp %0d got %0d", exp_w.match, res.match);
                        fail_count++;
                    end
                    if (res.out_length !== exp_w.out_length)
                    begin
                        $error("out_length exp %0d got %0d", exp_w.out_length, res.out_length);
                        fail_count++;
                    end
                    if (res.candidate !== exp_w.candidate)
                    begin
                        $error("candidate exp %h got %h", exp_w.candidate, res.candidate);
                        fail_count++;
                    end
                    if (res.digest_high !== exp_w.digest_high)
                    begin
                        $error("digest_high exp %h got %h", exp_w.digest_high, res.digest_high);
                        fail_count++;
                    end
                    if (res.digest_low !== exp_w.digest_low)
                    begin
                        $error("digest_low exp %h got %h", exp_w.digest_low, res.digest_low);
                        fail_count++;
                    end
                end
            end
            if (hold_cycles > 1)
                res.ready <= 1'b0;
            else if (allow_stall)
                res.ready <= ($urandom_range(0, 7) > 1);
            else
                res.ready <= 1'b1;
        end
    end

    task automatic test_directed();
        match_word_t m;
        send_candidate(3'd1, 26'd0);
        send_candidate(3'd1, 26'd35);
        send_candidate(3'd5, 26'd0);
        send_candidate(3'd5, 26'd60466175);
        send_candidate(3'd5, 26'h3FFFFFF);
        send_candidate(3'd0, 26'd7);
        send_candidate(3'd6, 26'd12345);
        send_candidate(3'd7, 26'h3FFFFFF);
        send_candidate(3'd2, 26'd1296);
        send_candidate(3'd3, 26'd46655);
        send_candidate(3'd4, 26'h2AAAAAA);
        send_candidate(3'd4, 26'h1555555);
        drain_pipe();
        // set the target to a real digest so the match flag fires
        m = predict_match(3'd3, 26'd1000);
        write_target(m.digest_high, m.digest_low);
        send_candidate(3'd3, 26'd1000);
        send_candidate(3'd3, 26'd1001);
        send_candidate(3'd3, 26'd47656);
        send_candidate(3'd4, 26'd1000);
        drain_pipe();
    endtask

    task automatic test_backpressure();
        allow_stall = 1'b0;
        hold_cycles = 200;
        for (int i = 0; i < 120; i++)
            send_candidate(3'($urandom_range(1, 5)), 26'($urandom));
        drain_pipe();
        allow_stall = 1'b1;
    endtask

    task automatic test_random(input int count);
        logic [2:0]  len;
        logic [25:0] idx;
        logic [25:0] tgt_idx;
        match_word_t m;
        tgt_idx = 26'($urandom);
        m = predict_match(3'd5, tgt_idx);
        write_target(m.digest_high, m.digest_low);
        for (int i = 0; i < count; i++)
        begin
            len = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 5));
            idx = 26'($urandom);
            // sometimes aim at the configured candidate
            if (i % 50 == 0)
            begin
                len = 3'd5;
                idx = tgt_idx;
            end
            send_candidate(len, idx);
            if (i % 200 == 199)
            begin
                drain_pipe();
                m = predict_match(3'd2, 26'($urandom_range(0, 1295)));
                write_target(m.digest_high, m.digest_low);
                for (int j = 0; j < 1296; j += 97)
                    send_candidate(3'd2, 26'(j));
            end
        end
        drain_pipe();
        write_target({64{1'b1}}, {64{1'b1}});
        for (int i = 0; i < 20; i++)
            send_candidate(3'($urandom_range(1, 5)), 26'($urandom));
        drain_pipe();
    endtask

    initial
    begin
        rst_n = 1'b0;
        fail_count = 0;
        hold_cycles = 0;
        allow_stall = 1'b1;
        target_hi = '0;
        target_lo = '0;
        cand.valid = 1'b0;
        cand.cand_length = '0;
        cand.cand_index = '0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(600);
        if (fail_count == 0)
            $display("base36_md5_candidate_matcher regression: pass");
        else
            $display("base36_md5_candidate_matcher regression: fail");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("base36_md5_candidate_matcher regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
hdl/b36md5_pkg.sv
hdl/b36md5_if.sv
hdl/base36_md5_candidate_matcher.sv
hdl/b36md5_checker.sv
sim/tb_base36_md5_candidate_matcher.sv
